### rtl/core/dv64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dv64_pkg
// Shared constants and types of the pipelined 64-bit restoring divider.
// ----------------------------------------------------------------------------
package dv64_pkg;

    // width of the operand and result ports
    localparam int unsigned FIELD_W            = 64;
    // default division width
    localparam int unsigned DATA_WIDTH_DEFAULT = 64;

    // sideband that travels with every transaction down the pipeline
    typedef struct packed {
        logic valid;
        logic neg_q;     // negate quotient at the end
        logic neg_r;     // negate remainder at the end
        logic div_zero;  // divisor was zero: force remainder to zero
    } t_dv64_ctrl;

endpackage

### rtl/core/divide_64_signed_unsigned_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divide_64_signed_unsigned_unit
// Pipelined restoring divider, signed or unsigned, quotient and remainder.
//
//   channel   handshake        payload
//   -------   --------------   ----------------------------------
//   command   start / busy     i_op, i_dividend, i_divisor
//   result    o_strobe         o_quotient, o_remainder
//
// One transaction enters per cycle and the result strobes out after passing
// through DATA_WIDTH + 2 register stages: one entry stage for magnitudes,
// one stage per quotient bit (one subtractor each), one exit stage for sign
// correction. Throughput is one transaction per cycle with no gaps.
// busy is high only while reset is applied; the result side never stalls.
// Reset clears the valid bits of all stages; data registers are not reset.
// ----------------------------------------------------------------------------
module divide_64_signed_unsigned_unit #(
    parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [dv64_pkg::FIELD_W-1:0] i_dividend,
    input  logic [dv64_pkg::FIELD_W-1:0] i_divisor,
    output logic                         o_strobe,
    output logic [dv64_pkg::FIELD_W-1:0] o_quotient,
    output logic [dv64_pkg::FIELD_W-1:0] o_remainder
);
    import dv64_pkg::*;

    t_dv64_ctrl            s_ctrl [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_rem  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_num  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_den  [DATA_WIDTH+1];

    assign busy     = ~i_rst_n;
    assign s_rem[0] = {DATA_WIDTH{1'b0}};

    dv64_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start & ~busy),
        .i_op       (i_op),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_ctrl     (s_ctrl[0]),
        .o_num      (s_num[0]),
        .o_den      (s_den[0])
    );

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        dv64_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (s_ctrl[g]),
            .i_rem   (s_rem[g]),
            .i_num   (s_num[g]),
            .i_den   (s_den[g]),
            .o_ctrl  (s_ctrl[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_num   (s_num[g+1]),
            .o_den   (s_den[g+1])
        );
    end

    // after the last step the dividend word holds the quotient magnitude
    dv64_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (s_ctrl[DATA_WIDTH]),
        .i_rem       (s_rem[DATA_WIDTH]),
        .i_quo       (s_num[DATA_WIDTH]),
        .o_strobe    (o_strobe),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

endmodule

### rtl/core/dv64_pre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dv64_pre
// Entry stage: masks operands to the division width, takes magnitudes in
// signed mode and records sign and divide-by-zero flags.
// ----------------------------------------------------------------------------
module dv64_pre #(
    parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_op,
    input  logic [dv64_pkg::FIELD_W-1:0]   i_dividend,
    input  logic [dv64_pkg::FIELD_W-1:0]   i_divisor,
    output dv64_pkg::t_dv64_ctrl           o_ctrl,
    output logic [DATA_WIDTH-1:0]          o_num,
    output logic [DATA_WIDTH-1:0]          o_den
);
    import dv64_pkg::*;

    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic                  na;
    logic                  nb;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;

    logic                  r_valid;
    logic                  r_neg_q;
    logic                  r_neg_r;
    logic                  r_div_zero;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;

    always_comb begin
        a     = i_dividend[DATA_WIDTH-1:0];
        b     = i_divisor[DATA_WIDTH-1:0];
        na    = i_op & a[DATA_WIDTH-1];
        nb    = i_op & b[DATA_WIDTH-1];
        a_mag = na ? ({DATA_WIDTH{1'b0}} - a) : a;
        b_mag = nb ? ({DATA_WIDTH{1'b0}} - b) : b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_q    <= na ^ nb;
        r_neg_r    <= na;
        r_div_zero <= (b == {DATA_WIDTH{1'b0}});
        r_num      <= a_mag;
        r_den      <= b_mag;
    end

    assign o_ctrl = '{valid: r_valid, neg_q: r_neg_q, neg_r: r_neg_r,
                      div_zero: r_div_zero};
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

### rtl/core/dv64_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dv64_step
// One restoring shift-and-subtract step, registered. The dividend word
// shifts left each step and collects quotient bits at its low end.
// ----------------------------------------------------------------------------
module dv64_step #(
    parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dv64_pkg::t_dv64_ctrl  i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output dv64_pkg::t_dv64_ctrl  o_ctrl,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_num,
    output logic [DATA_WIDTH-1:0] o_den
);
    import dv64_pkg::*;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  borrow;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_num;

    logic                  r_valid;
    logic                  r_neg_q;
    logic                  r_neg_r;
    logic                  r_div_zero;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;

    always_comb begin
        // bring in the next dividend bit, then trial subtract
        shifted        = {i_rem, i_num[DATA_WIDTH-1]};
        {borrow, diff} = {1'b0, shifted} - {2'b00, i_den};
        ge             = ~borrow;
        n_rem          = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n_num          = {i_num[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_q    <= i_ctrl.neg_q;
        r_neg_r    <= i_ctrl.neg_r;
        r_div_zero <= i_ctrl.div_zero;
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_den      <= i_den;
    end

    assign o_ctrl = '{valid: r_valid, neg_q: r_neg_q, neg_r: r_neg_r,
                      div_zero: r_div_zero};
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

### rtl/core/dv64_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dv64_post
// Exit stage: applies the sign of quotient and remainder, clears the
// remainder on divide by zero and drives the registered result.
// ----------------------------------------------------------------------------
module dv64_post #(
    parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dv64_pkg::t_dv64_ctrl         i_ctrl,
    input  logic [DATA_WIDTH-1:0]        i_rem,
    input  logic [DATA_WIDTH-1:0]        i_quo,
    output logic                         o_strobe,
    output logic [dv64_pkg::FIELD_W-1:0] o_quotient,
    output logic [dv64_pkg::FIELD_W-1:0] o_remainder
);
    import dv64_pkg::*;

    logic [DATA_WIDTH-1:0] rem_raw;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] n_rem;

    logic                  r_strobe;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_rem;

    always_comb begin
        rem_raw = i_ctrl.div_zero ? {DATA_WIDTH{1'b0}} : i_rem;
        n_quo   = i_ctrl.neg_q ? ({DATA_WIDTH{1'b0}} - i_quo) : i_quo;
        n_rem   = i_ctrl.neg_r ? ({DATA_WIDTH{1'b0}} - rem_raw) : rem_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    // upper bits beyond the division width read as zero
    assign o_strobe    = r_strobe;
    assign o_quotient  = FIELD_W'(r_quo);
    assign o_remainder = FIELD_W'(r_rem);

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined signed/unsigned 64-bit divider.
//
// A queue of division commands (directed corner cases, then random operand
// pairs of mixed magnitude and sign) feeds a clocked driver that issues them
// in random bursts. Each accepted transaction gets its quotient and
// remainder worked out by a bit-serial restoring divider in the bench; a
// clocked monitor compares every strobed result with the oldest one pending.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned FW         = dv64_pkg::FIELD_W;
    localparam int unsigned DW         = dv64_pkg::DATA_WIDTH_DEFAULT;
    localparam int unsigned PERIOD     = 10;
    localparam int unsigned PIPE_DEPTH = DW + 2;
    localparam int unsigned TAIL       = PIPE_DEPTH + 20;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned N_RANDOM   = 550;
    localparam int unsigned MAX_PRINTS = 50;

    localparam logic [FW-1:0] MASK = {FW{1'b1}} >> (FW - DW);
    localparam logic [FW-1:0] SIGN = {{(FW-1){1'b0}}, 1'b1} << (DW - 1);

    typedef enum logic {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } t_div_op;

    typedef struct {
        t_div_op       op;
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        bit            drain;     // wait for the pipeline to empty first
    } t_div_cmd;

    typedef struct {
        t_div_op       op;
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        logic [FW-1:0] quotient;
        logic [FW-1:0] remainder;
    } t_div_result;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    logic          i_op        = 1'b0;
    logic [FW-1:0] i_dividend  = '0;
    logic [FW-1:0] i_divisor   = '0;
    logic          busy;
    logic          o_strobe;
    logic [FW-1:0] o_quotient;
    logic [FW-1:0] o_remainder;

    t_div_cmd    div_cmd_q[$];
    t_div_result quot_rem_q[$];

    int unsigned err_count     = 0;
    int unsigned sent_count    = 0;
    int unsigned signed_count  = 0;
    int unsigned zero_count    = 0;
    int unsigned checked_count = 0;
    int unsigned idle_cycles   = 0;
    int unsigned burst_left    = 1;
    int unsigned gap_left      = 0;

    divide_64_signed_unsigned_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_strobe    (o_strobe),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // Restoring division on magnitudes, then sign correction.
    function automatic t_div_result calc_division(t_div_op op, logic [FW-1:0] num,
                                                  logic [FW-1:0] den);
        t_div_result res;
        logic        neg_a;
        logic        neg_b;
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic [FW-1:0] q;
        logic [FW:0]   r;
        int            i;
        a     = num & MASK;
        b     = den & MASK;
        neg_a = (op == OP_SIGNED) && ((a & SIGN) != '0);
        neg_b = (op == OP_SIGNED) && ((b & SIGN) != '0);
        if (neg_a) a = (-a) & MASK;
        if (neg_b) b = (-b) & MASK;
        q = '0;
        r = '0;
        if (b == '0) begin
            q = MASK;
        end else begin
            for (i = DW - 1; i >= 0; i--) begin
                r = {r[FW-1:0], a[i]};
                if (r >= {1'b0, b}) begin
                    r    = r - {1'b0, b};
                    q[i] = 1'b1;
                end
            end
        end
        if (neg_a != neg_b) q = -q;
        res.op        = op;
        res.dividend  = num;
        res.divisor   = den;
        res.quotient  = q & MASK;
        res.remainder = (neg_a ? -r[FW-1:0] : r[FW-1:0]) & MASK;
        return res;
    endfunction

    function automatic logic [FW-1:0] rand_operand();
        logic [FW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4, 5:       v = {$urandom, $urandom} >> $urandom_range(0, FW - 1);
            6:          v = FW'($urandom_range(0, 255));
            7: begin
                case ($urandom_range(0, 6))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = 2;
                    3:       v = MASK;
                    4:       v = SIGN;
                    5:       v = SIGN - 1;
                    default: v = SIGN + 1;
                endcase
            end
            8:       v = SIGN >> $urandom_range(0, DW - 1);
            default: v = {$urandom, $urandom} >> $urandom_range(DW / 2, FW - 1);
        endcase
        // flip to the negative side now and then
        if ($urandom_range(0, 9) >= 6) v = -v;
        return v;
    endfunction

    task automatic add_cmd(t_div_op op, logic [FW-1:0] num, logic [FW-1:0] den,
                           bit drain = 1'b0);
        t_div_cmd c;
        c.op       = op;
        c.dividend = num;
        c.divisor  = den;
        c.drain    = drain;
        div_cmd_q.push_back(c);
    endtask

    task automatic report_mismatch(string what, t_div_result ref_res,
                                   logic [FW-1:0] got, logic [FW-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t mismatch %s: op=%0d a=%h b=%h got=%h exp=%h", $realtime, what,
                     ref_res.op, ref_res.dividend, ref_res.divisor, got, want);
    endtask

    // Driver: issue commands in bursts, hold a drain command until nothing is pending.
    always @(posedge i_clk) begin : driver
        t_div_cmd nxt;
        logic     take;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = 1'b0;
            if (start && !busy) begin
                quot_rem_q.push_back(calc_division(t_div_op'(i_op), i_dividend, i_divisor));
                sent_count++;
                if (i_op == OP_SIGNED) signed_count++;
                if ((i_divisor & MASK) == '0) zero_count++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (div_cmd_q.size() != 0 &&
                             !(div_cmd_q[0].drain && quot_rem_q.size() != 0)) begin
                    take = 1'b1;
                end
            end
            if (take) begin
                nxt = div_cmd_q.pop_front();
                i_op       <= nxt.op;
                i_dividend <= nxt.dividend;
                i_divisor  <= nxt.divisor;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            start <= take || (start && busy);
        end
    end

    // Monitor: every strobe must match the oldest pending transaction.
    always @(posedge i_clk) begin : monitor
        t_div_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (quot_rem_q.size() == 0) begin
                want          = '{OP_UNSIGNED, '0, '0, '0, '0};
                report_mismatch("result with nothing pending", want, o_quotient, '0);
            end else begin
                want = quot_rem_q.pop_front();
                checked_count++;
                if (o_quotient !== want.quotient)
                    report_mismatch("quotient", want, o_quotient, want.quotient);
                if (o_remainder !== want.remainder)
                    report_mismatch("remainder", want, o_remainder, want.remainder);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe === 1'b1) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        logic [FW-1:0] den;

        // corner cases, both modes where it matters
        add_cmd(OP_UNSIGNED, '0, '0);
        add_cmd(OP_UNSIGNED, MASK, '0);
        add_cmd(OP_SIGNED, 25, '0);
        add_cmd(OP_SIGNED, -25, '0);
        add_cmd(OP_SIGNED, '0, '0);
        add_cmd(OP_SIGNED, SIGN, MASK);
        add_cmd(OP_SIGNED, SIGN, 1);
        add_cmd(OP_UNSIGNED, SIGN, MASK);
        add_cmd(OP_UNSIGNED, MASK, 1);
        add_cmd(OP_UNSIGNED, MASK, MASK);
        add_cmd(OP_UNSIGNED, MASK, 2);
        add_cmd(OP_UNSIGNED, '0, MASK);
        add_cmd(OP_UNSIGNED, 5, 7);
        add_cmd(OP_SIGNED, -7, 2);
        add_cmd(OP_SIGNED, 7, -2);
        add_cmd(OP_SIGNED, -7, -2);
        add_cmd(OP_SIGNED, 7, 2);
        add_cmd(OP_SIGNED, SIGN - 1, SIGN);
        add_cmd(OP_SIGNED, SIGN, SIGN);
        add_cmd(OP_SIGNED, SIGN - 1, -1);
        add_cmd(OP_UNSIGNED, 64'h0123_4567_89ab_cdef, 64'h0000_0000_0001_0000);
        add_cmd(OP_SIGNED, MASK, MASK);

        for (n = 0; n < N_RANDOM; n++) begin
            den = rand_operand();
            if ($urandom_range(0, 24) == 0) den = '0;
            add_cmd($urandom_range(0, 1) ? OP_SIGNED : OP_UNSIGNED, rand_operand(), den,
                    n == 0 || n == N_RANDOM / 2);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (div_cmd_q.size() != 0 || start) @(posedge i_clk);
        while (quot_rem_q.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("Issued %0d divisions (%0d signed, %0d by zero), %0d results checked.",
                 sent_count, signed_count, zero_count, checked_count);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/dv64_pkg.sv
rtl/core/dv64_pre.sv
rtl/core/dv64_step.sv
rtl/core/dv64_post.sv
rtl/core/divide_64_signed_unsigned_unit.sv
dv/tb.sv
